// File: rtl/core/wtqs_pkg.sv
// Package for the weighted two-queue server.
// Holds the command and status codes, the controller states and the
// structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package wtqs_pkg;

	typedef enum logic [1:0] {
		CMD_ENQ_A = 2'd0,
		CMD_ENQ_B = 2'd1,
		CMD_SERVE = 2'd2,
		CMD_POP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_NONE   = 2'd2,
		ST_H_FULL = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		SEL_NONE = 2'd0,
		SEL_A    = 2'd1,
		SEL_B    = 2'd2
	} sel_t;

	typedef enum logic [0:0] {
		FSM_IDLE = 1'b0,
		FSM_READ = 1'b1
	} fsm_t;

	localparam logic [3:0] WEIGHT_RESET = 4'd3;

	typedef struct packed {
		logic capture;
		logic commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic out_valid;
	} dp_stat_t;

endpackage

// File: rtl/core/wtqs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module wtqs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/core/wtqs_ctrl.sv
// Controller state machine of the weighted two-queue server.
// Depends on wtqs_pkg.
`timescale 1ns / 1ps

module wtqs_ctrl
	import wtqs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  logic     rsp_stall,
	input  dp_stat_t stat,
	output ctl_cmd_t ctl
);

	fsm_t state_q, state_d;
	logic can_commit;

	assign can_commit = !stat.out_valid || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (req_valid) state_d = FSM_READ;
			end
			FSM_READ: begin
				if (can_commit) state_d = FSM_IDLE;
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_comb begin
		req_stall   = 1'b1;
		ctl.capture = 1'b0;
		ctl.commit  = 1'b0;
		unique case (state_q)
			FSM_IDLE: begin
				req_stall   = 1'b0;
				ctl.capture = req_valid;
			end
			FSM_READ: begin
				ctl.commit = can_commit;
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/core/wtqs_dp.sv
// Datapath of the weighted two-queue server: queue and history pointers,
// round phase, weight register, the three RAMs and the result register.
// Depends on wtqs_pkg and wtqs_ram.
`timescale 1ns / 1ps

module wtqs_dp
	import wtqs_pkg::*;
#(
	parameter int QUEUE_DEPTH   = 16,
	parameter int HISTORY_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_cmd_t    ctl,
	output dp_stat_t    stat,
	input  cmd_t        cmd,
	input  logic [15:0] item_id,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	input  logic        rsp_stall,
	output logic [15:0] out_id,
	output logic        from_queue,
	output status_t     status
);

	localparam int QAW = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int HAW = $clog2(HISTORY_DEPTH);
	localparam int HTW = $clog2(HISTORY_DEPTH + 1);
	localparam logic [QAW-1:0] Q_LAST = QAW'(QUEUE_DEPTH - 1);
	localparam logic [QCW-1:0] Q_FULL = QCW'(QUEUE_DEPTH);
	localparam logic [HTW-1:0] H_FULL = HTW'(HISTORY_DEPTH);

	logic [3:0]     weight_q;
	logic [3:0]     phase_q;
	logic [QAW-1:0] a_head_q, a_tail_q, b_head_q, b_tail_q;
	logic [QCW-1:0] a_cnt_q, b_cnt_q;
	logic [HTW-1:0] top_q;

	cmd_t        cmd_s1;
	logic [15:0] id_s1;
	sel_t        sel_s1;
	logic [3:0]  phase_s1;

	logic        out_valid_q;
	logic [15:0] out_id_q;
	logic        from_q_q;
	status_t     status_q;

	sel_t        sel_d;
	logic [3:0]  phase_d;
	logic        a_ne, b_ne;
	logic [15:0] qa_rdata, qb_rdata, h_rdata, served_id;
	logic        qa_we, qb_we, h_we;
	logic [HTW-1:0] top_m1;
	logic [15:0] res_id_d;
	logic        res_q_d;
	status_t     res_st_d;

	assign a_ne   = a_cnt_q != '0;
	assign b_ne   = b_cnt_q != '0;
	assign top_m1 = top_q - HTW'(1);

	always_comb begin
		sel_d   = SEL_NONE;
		phase_d = phase_q;
		priority if (phase_q < weight_q && a_ne) begin
			sel_d   = SEL_A;
			phase_d = phase_q + 4'd1;
		end else if (b_ne) begin
			sel_d   = SEL_B;
			phase_d = 4'd0;
		end else if (a_ne) begin
			sel_d   = SEL_A;
			phase_d = 4'd1;
		end
	end

	assign qa_we = ctl.commit && cmd_s1 == CMD_ENQ_A && a_cnt_q != Q_FULL;
	assign qb_we = ctl.commit && cmd_s1 == CMD_ENQ_B && b_cnt_q != Q_FULL;
	assign h_we  = ctl.commit && cmd_s1 == CMD_SERVE && sel_s1 != SEL_NONE
		&& top_q != H_FULL;
	assign served_id = (sel_s1 == SEL_B) ? qb_rdata : qa_rdata;

	wtqs_ram #(.WIDTH(16), .DEPTH(QUEUE_DEPTH)) u_qa (
		.clk   (clk),
		.we    (qa_we),
		.waddr (a_tail_q),
		.wdata (id_s1),
		.re    (ctl.capture && cmd == CMD_SERVE && sel_d == SEL_A),
		.raddr (a_head_q),
		.rdata (qa_rdata)
	);

	wtqs_ram #(.WIDTH(16), .DEPTH(QUEUE_DEPTH)) u_qb (
		.clk   (clk),
		.we    (qb_we),
		.waddr (b_tail_q),
		.wdata (id_s1),
		.re    (ctl.capture && cmd == CMD_SERVE && sel_d == SEL_B),
		.raddr (b_head_q),
		.rdata (qb_rdata)
	);

	wtqs_ram #(.WIDTH(16), .DEPTH(HISTORY_DEPTH)) u_hist (
		.clk   (clk),
		.we    (h_we),
		.waddr (top_q[HAW-1:0]),
		.wdata (served_id),
		.re    (ctl.capture && cmd == CMD_POP && top_q != '0),
		.raddr (top_m1[HAW-1:0]),
		.rdata (h_rdata)
	);

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_s1   <= cmd;
			id_s1    <= item_id;
			sel_s1   <= sel_d;
			phase_s1 <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q    <= WEIGHT_RESET;
			phase_q     <= '0;
			a_head_q    <= '0;
			a_tail_q    <= '0;
			a_cnt_q     <= '0;
			b_head_q    <= '0;
			b_tail_q    <= '0;
			b_cnt_q     <= '0;
			top_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) weight_q <= cfg_wdata;
			if (out_valid_q && !rsp_stall && !ctl.commit) out_valid_q <= 1'b0;
			if (ctl.commit) begin
				out_valid_q <= 1'b1;
				unique case (cmd_s1)
					CMD_ENQ_A: begin
						if (qa_we) begin
							a_tail_q <= (a_tail_q == Q_LAST) ? '0 : a_tail_q + QAW'(1);
							a_cnt_q  <= a_cnt_q + QCW'(1);
						end
					end
					CMD_ENQ_B: begin
						if (qb_we) begin
							b_tail_q <= (b_tail_q == Q_LAST) ? '0 : b_tail_q + QAW'(1);
							b_cnt_q  <= b_cnt_q + QCW'(1);
						end
					end
					CMD_SERVE: begin
						if (sel_s1 != SEL_NONE) phase_q <= phase_s1;
						if (sel_s1 == SEL_A) begin
							a_head_q <= (a_head_q == Q_LAST) ? '0 : a_head_q + QAW'(1);
							a_cnt_q  <= a_cnt_q - QCW'(1);
						end
						if (sel_s1 == SEL_B) begin
							b_head_q <= (b_head_q == Q_LAST) ? '0 : b_head_q + QAW'(1);
							b_cnt_q  <= b_cnt_q - QCW'(1);
						end
						if (h_we) top_q <= top_q + HTW'(1);
					end
					CMD_POP: begin
						if (top_q != '0) top_q <= top_m1;
					end
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		res_id_d = '0;
		res_q_d  = 1'b0;
		res_st_d = ST_OK;
		unique case (cmd_s1)
			CMD_ENQ_A: begin
				if (!qa_we) res_st_d = ST_FULL;
			end
			CMD_ENQ_B: begin
				if (!qb_we) res_st_d = ST_FULL;
			end
			CMD_SERVE: begin
				if (sel_s1 == SEL_NONE) begin
					res_st_d = ST_NONE;
				end else begin
					res_id_d = served_id;
					res_q_d  = sel_s1 == SEL_B;
					if (!h_we) res_st_d = ST_H_FULL;
				end
			end
			CMD_POP: begin
				if (top_q != '0) begin
					res_id_d = h_rdata;
				end else begin
					res_st_d = ST_NONE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			out_id_q <= res_id_d;
			from_q_q <= res_q_d;
			status_q <= res_st_d;
		end
	end

	assign stat.out_valid = out_valid_q;
	assign out_id         = out_id_q;
	assign from_queue     = from_q_q;
	assign status         = status_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		a_cnt_q <= Q_FULL) else $error("queue A count exceeds depth");

	b_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		b_cnt_q <= Q_FULL) else $error("queue B count exceeds depth");

	top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= H_FULL) else $error("history top exceeds depth");

	commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |=> out_valid_q) else $error("committed result not presented");

	no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |-> (!out_valid_q || !rsp_stall))
		else $error("result register overwritten while stalled");

endmodule

// File: rtl/core/weighted_two_queue_server.sv
// Top level of the weighted two-queue server.
// Depends on wtqs_pkg, wtqs_ctrl and wtqs_dp.
//
// channel   valid      stall      payload
// request   req_valid  req_stall  cmd, item_id
// response  rsp_valid  rsp_stall  out_id, from_queue, status
// config    cfg_we     -          cfg_wdata (weight_a)
//
// Each transaction is captured in FSM_IDLE, which reads the queue or history RAM,
// and committed in FSM_READ, because every RAM read is registered.
// The response register lets the next request be captured while a result waits.
// A stalled response holds the following transaction in its commit cycle.
// Reset clears pointers, counts and phase and sets the weight to WEIGHT_RESET; RAM contents are not cleared.
`timescale 1ns / 1ps

module weighted_two_queue_server
	import wtqs_pkg::*;
#(
	parameter int QUEUE_DEPTH   = 16,
	parameter int HISTORY_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  cmd,
	input  logic [15:0] item_id,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [15:0] out_id,
	output logic        from_queue,
	output logic [1:0]  status,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata
);

	ctl_cmd_t ctl;
	dp_stat_t stat;
	status_t  status_e;

	wtqs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	wtqs_dp #(
		.QUEUE_DEPTH   (QUEUE_DEPTH),
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.cmd        (cmd_t'(cmd)),
		.item_id    (item_id),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.rsp_stall  (rsp_stall),
		.out_id     (out_id),
		.from_queue (from_queue),
		.status     (status_e)
	);

	assign rsp_valid = stat.out_valid;
	assign status    = status_e;

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for weighted_two_queue_server: directed and random command
// streams under random idling and backpressure, each response checked against a model.
// Depends on wtqs_pkg and the weighted_two_queue_server RTL.
`timescale 1ns / 1ps

module tb_top;
	import wtqs_pkg::*;

	localparam int Q_DEPTH = 16;
	localparam int H_DEPTH = 32;

	typedef struct packed {
		logic [15:0] id;
		logic        q;
		status_t     st;
	} rsp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [1:0]  cmd = CMD_ENQ_A;
	logic [15:0] item_id = 16'd0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [15:0] out_id;
	logic        from_queue;
	logic [1:0]  status;
	logic        cfg_we = 1'b0;
	logic [3:0]  cfg_wdata = WEIGHT_RESET;

	logic [15:0] queue_a[$];
	logic [15:0] queue_b[$];
	logic [15:0] history[$];
	logic [3:0]  a_phase = 4'd0;
	logic [3:0]  weight = WEIGHT_RESET;
	rsp_t        pending_responses[$];

	int errors = 0;
	int hold_len = 0;
	bit idle_on = 1'b1;
	bit stall_on = 1'b1;

	weighted_two_queue_server #(
		.QUEUE_DEPTH(Q_DEPTH),
		.HISTORY_DEPTH(H_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.cmd(cmd),
		.item_id(item_id),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.out_id(out_id),
		.from_queue(from_queue),
		.status(status),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("ERROR at %0t: %s", $time, what);
		errors++;
	endtask

	function automatic rsp_t next_response(input cmd_t c, input logic [15:0] id);
		rsp_t r;
		logic served;
		r.id = 16'd0;
		r.q = 1'b0;
		r.st = ST_OK;
		served = 1'b1;
		case (c)
			CMD_ENQ_A: begin
				if (queue_a.size() < Q_DEPTH) queue_a.push_back(id);
				else r.st = ST_FULL;
			end
			CMD_ENQ_B: begin
				if (queue_b.size() < Q_DEPTH) queue_b.push_back(id);
				else r.st = ST_FULL;
			end
			CMD_SERVE: begin
				if (a_phase < weight && queue_a.size() != 0) begin
					r.id = queue_a.pop_front();
					a_phase = a_phase + 4'd1;
				end else if (queue_b.size() != 0) begin
					r.id = queue_b.pop_front();
					r.q = 1'b1;
					a_phase = 4'd0;
				end else if (queue_a.size() != 0) begin
					r.id = queue_a.pop_front();
					a_phase = 4'd1;
				end else begin
					served = 1'b0;
					r.st = ST_NONE;
				end
				if (served) begin
					if (history.size() < H_DEPTH) history.push_back(r.id);
					else r.st = ST_H_FULL;
				end
			end
			default: begin
				if (history.size() != 0) r.id = history.pop_back();
				else r.st = ST_NONE;
			end
		endcase
		return r;
	endfunction

	function automatic int sender_gap();
		int r;
		if (!idle_on) return 0;
		r = $urandom_range(0, 9);
		if (r < 5) return 0;
		if (r < 9) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic cmd_t pick_cmd(input int enq_pct, input int srv_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < enq_pct) return ($urandom_range(0, 1) == 0) ? CMD_ENQ_A : CMD_ENQ_B;
		if (r < enq_pct + srv_pct) return CMD_SERVE;
		return CMD_POP;
	endfunction

	task automatic send_item(input cmd_t c, input logic [15:0] id);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		cmd <= c;
		item_id <= id;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		pending_responses.push_back(next_response(c, id));
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		while (pending_responses.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_weight(input logic [3:0] w);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_we <= 1'b0;
		weight = w;
	endtask

	always begin : rsp_pacer
		int n;
		@(posedge clk);
		if (hold_len > 0) begin
			rsp_stall <= 1'b1;
			repeat (hold_len) @(posedge clk);
			hold_len = 0;
			rsp_stall <= 1'b0;
		end else if (stall_on && $urandom_range(0, 3) == 0) begin
			n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
			rsp_stall <= 1'b1;
			repeat (n) @(posedge clk);
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_responses.size() == 0) begin
				report_mismatch("response with no transaction outstanding");
			end else begin
				want = pending_responses.pop_front();
				if (out_id !== want.id)
					report_mismatch($sformatf("out_id %h, expected %h", out_id, want.id));
				if (from_queue !== want.q)
					report_mismatch($sformatf("from_queue %b, expected %b", from_queue, want.q));
				if (status !== want.st)
					report_mismatch($sformatf("status %0d, expected %s", status, want.st.name()));
			end
		end
	end

	task automatic test_empty();
		send_item(CMD_SERVE, 16'hFFFF);
		send_item(CMD_POP, 16'hFFFF);
	endtask

	task automatic test_extremes();
		send_item(CMD_ENQ_A, 16'h0000);
		send_item(CMD_ENQ_A, 16'hFFFF);
		send_item(CMD_ENQ_B, 16'hFFFF);
		send_item(CMD_ENQ_B, 16'h0000);
		repeat (4) send_item(CMD_SERVE, 16'h0000);
		send_item(CMD_POP, 16'h5A5A);
		send_item(CMD_POP, 16'hA5A5);
	endtask

	task automatic test_weight_zero();
		write_weight(4'd0);
		send_item(CMD_ENQ_B, 16'h1234);
		send_item(CMD_ENQ_A, 16'hFEDC);
		send_item(CMD_SERVE, 16'h0000);
		send_item(CMD_SERVE, 16'h0000);
	endtask

	task automatic test_weight_lowered();
		write_weight(4'd15);
		send_item(CMD_ENQ_A, 16'h00A1);
		send_item(CMD_ENQ_A, 16'h00A2);
		send_item(CMD_ENQ_A, 16'h00A3);
		send_item(CMD_ENQ_B, 16'h00B1);
		send_item(CMD_SERVE, 16'h0000);
		send_item(CMD_SERVE, 16'h0000);
		write_weight(4'd1);
		send_item(CMD_SERVE, 16'h0000);
		send_item(CMD_SERVE, 16'h0000);
	endtask

	task automatic test_random_traffic();
		int enq_pct;
		int srv_pct;
		logic [3:0] w;
		for (int p = 0; p < 16; p++) begin
			case (p % 6)
				0: w = 4'd1;
				1: w = 4'd15;
				2: w = 4'd0;
				3: w = WEIGHT_RESET;
				default: w = 4'($urandom_range(0, 15));
			endcase
			write_weight(w);
			idle_on = (p % 3 != 0);
			stall_on = (p % 4 != 1);
			case (p % 4)
				0: begin enq_pct = 55; srv_pct = 35; end
				1: begin enq_pct = 80; srv_pct = 15; end
				2: begin enq_pct = 20; srv_pct = 70; end
				default: begin enq_pct = 30; srv_pct = 20; end
			endcase
			repeat (120) send_item(pick_cmd(enq_pct, srv_pct), 16'($urandom_range(0, 65535)));
		end
	endtask

	task automatic test_backpressure();
		wait_idle();
		idle_on = 1'b0;
		stall_on = 1'b0;
		hold_len = 250;
		repeat (40) send_item(pick_cmd(50, 40), 16'($urandom_range(0, 65535)));
		wait_idle();
		idle_on = 1'b1;
		stall_on = 1'b1;
		repeat (40) send_item(pick_cmd(40, 40), 16'($urandom_range(0, 65535)));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty();
		test_extremes();
		test_weight_zero();
		test_weight_lowered();
		test_random_traffic();
		test_backpressure();
		wait_idle();
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// File: weighted_two_queue_server.f
rtl/core/wtqs_pkg.sv
rtl/core/wtqs_ram.sv
rtl/core/wtqs_ctrl.sv
rtl/core/wtqs_dp.sv
rtl/core/weighted_two_queue_server.sv
sim/tb_top.sv
